@@ hw/rtl/euler_yxz_view_matrix_unit_macros.svh @@
// Assertion macros for the euler_yxz_view_matrix_unit design
`ifndef EULER_YXZ_VIEW_MATRIX_UNIT_MACROS_SVH
`define EULER_YXZ_VIEW_MATRIX_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define EYV_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`define EYV_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define EYV_ASSERT_NEVER(lbl, expr, msg)
`define EYV_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

@@ hw/rtl/eyv_pkg.sv @@
// Shared constants, types and arithmetic helpers of the view matrix unit
package eyv_pkg;

	localparam int ANGLE_BITS      = 16;
	localparam int TRIG_FRAC_BITS  = 14;
	localparam int CORDIC_TAB_LEN  = 24;
	localparam int CORDIC_ONE_FRAC = 30;
	localparam int CORDIC_STEPS    = (TRIG_FRAC_BITS + 2 > CORDIC_TAB_LEN) ?
		CORDIC_TAB_LEN : TRIG_FRAC_BITS + 2;
	localparam int CORDIC_X0       = 652032874;

	localparam int XY_W   = 34;
	localparam int Z_W    = ANGLE_BITS + 2;
	localparam int TRIG_W = TRIG_FRAC_BITS + 2;
	localparam int SUM_W  = TRIG_FRAC_BITS + 3;
	localparam int PROD_W = TRIG_W + 32;
	localparam int ACC_W  = TRIG_FRAC_BITS + 37;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;

	localparam logic [31:0] ATAN32 [CORDIC_TAB_LEN] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
	};

	typedef logic signed [TRIG_W-1:0] trig_t;
	typedef logic signed [XY_W-1:0]   xy_t;
	typedef logic signed [Z_W-1:0]    z_t;

	// lane order: 0 yaw, 1 pitch, 2 roll
	typedef struct packed {
		logic [2:0][1:0]            quad;
		logic [2:0][ANGLE_BITS-1:0] resid;
		logic signed [31:0]         pos_x;
		logic signed [31:0]         pos_y;
		logic signed [31:0]         pos_z;
	} fe_t;

	typedef struct packed {
		logic [2:0][1:0]    quad;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} side_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic [FIFO_PTR_W:0] count;
	} fq_stat_t;

	typedef struct packed {
		logic [15:0] right_x;
		logic [15:0] right_y;
		logic [15:0] right_z;
		logic [15:0] up_x;
		logic [15:0] up_y;
		logic [15:0] up_z;
		logic [15:0] fwd_x;
		logic [15:0] fwd_y;
		logic [15:0] fwd_z;
		logic [31:0] shift_u;
		logic [31:0] shift_v;
		logic [31:0] shift_w;
	} res_t;

	// arctangent step in A-bit turn units, rounded half up
	function automatic z_t atan_step(int i);
		logic [32:0] v;
		v = {1'b0, ATAN32[i]} + (33'd1 << (31 - ANGLE_BITS));
		return Z_W'(v >> (32 - ANGLE_BITS));
	endfunction

	function automatic trig_t uclamp(logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] lim;
		lim = SUM_W'(1 << TRIG_FRAC_BITS);
		if (v > lim)
			return TRIG_W'(lim);
		else if (v < -lim)
			return TRIG_W'(-lim);
		return TRIG_W'(v);
	endfunction

	function automatic trig_t fmul(trig_t a, trig_t b);
		logic signed [2*TRIG_W-1:0] pr;
		pr = a * b;
		pr = pr + (2*TRIG_W)'(1 << (TRIG_FRAC_BITS - 1));
		return TRIG_W'(pr >>> TRIG_FRAC_BITS);
	endfunction

	// Q30 to QF, round half up, clamp to unit range
	function automatic trig_t rnd_q30(xy_t x);
		logic signed [XY_W:0] t;
		t = (XY_W+1)'(x) + (XY_W+1)'(1 << (CORDIC_ONE_FRAC - TRIG_FRAC_BITS - 1));
		t = t >>> (CORDIC_ONE_FRAC - TRIG_FRAC_BITS);
		return uclamp(SUM_W'(t));
	endfunction

	function automatic logic [31:0] sat32(logic signed [ACC_W-1:0] a);
		logic signed [ACC_W-1:0] r;
		r = (-a + ACC_W'(1 << (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS;
		if (r > ACC_W'(64'sd2147483647))
			return 32'h7FFF_FFFF;
		else if (r < -ACC_W'(64'sd2147483648))
			return 32'h8000_0000;
		return r[31:0];
	endfunction

endpackage

@@ hw/rtl/eyv_front.sv @@
// Input queue: takes pose items, splits each angle into quadrant and residual
module eyv_front import eyv_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic signed [15:0]    pitch_angle,
	input  logic signed [15:0]    yaw_angle,
	input  logic signed [15:0]    roll_angle,
	input  logic signed [31:0]    pos_x,
	input  logic signed [31:0]    pos_y,
	input  logic signed [31:0]    pos_z,
	input  logic                  rd_en,
	output fe_t                   rd_data,
	output fq_stat_t              stat
);
	fe_t                 mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W:0] wr_q;
	logic [FIFO_PTR_W:0] rd_q;
	logic [FIFO_PTR_W:0] count;
	logic [2:0][15:0]    ang;
	fe_t                 cls;
	logic                wr_en;

	assign ang = {roll_angle, pitch_angle, yaw_angle};

	always_comb begin
		cls.pos_x = pos_x;
		cls.pos_y = pos_y;
		cls.pos_z = pos_z;
		for (int l = 0; l < 3; l++) begin
			logic [31:0]            turn;
			logic [ANGLE_BITS-1:0]  ph;
			logic [ANGLE_BITS-1:0]  ps;
			turn = {ang[l], 16'h0000};
			ph = turn[31 -: ANGLE_BITS];
			ps = ph + (ANGLE_BITS'(1) << (ANGLE_BITS - 3));
			cls.quad[l] = ps[ANGLE_BITS-1 -: 2];
			cls.resid[l] = ph - {ps[ANGLE_BITS-1 -: 2], (ANGLE_BITS-2)'(0)};
		end
	end

	assign count = wr_q - rd_q;
	assign full  = count[FIFO_PTR_W];
	assign wr_en = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (wr_en)
				wr_q <= wr_q + 1'b1;
			if (rd_en)
				rd_q <= rd_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_q[FIFO_PTR_W-1:0]] <= cls;
	end

	assign rd_data    = mem_q[rd_q[FIFO_PTR_W-1:0]];
	assign stat.empty = (wr_q == rd_q);
	assign stat.full  = full;
	assign stat.count = count;
endmodule

@@ hw/rtl/eyv_cordic.sv @@
// Pipelined rotation CORDIC, three lanes side by side, one step per stage
module eyv_cordic import eyv_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      in_vld,
	input  fe_t       in_data,
	output logic      out_vld,
	output xy_t [2:0] out_x,
	output xy_t [2:0] out_y,
	output side_t     out_side
);
	logic  vld_s  [CORDIC_STEPS+1];
	xy_t   x_s    [CORDIC_STEPS+1][3];
	xy_t   y_s    [CORDIC_STEPS+1][3];
	z_t    z_s    [CORDIC_STEPS+1][3];
	side_t side_s [CORDIC_STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s[0] <= 1'b0;
		else if (en)
			vld_s[0] <= in_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0].quad  <= in_data.quad;
			side_s[0].pos_x <= in_data.pos_x;
			side_s[0].pos_y <= in_data.pos_y;
			side_s[0].pos_z <= in_data.pos_z;
			for (int l = 0; l < 3; l++) begin
				x_s[0][l] <= XY_W'(CORDIC_X0);
				y_s[0][l] <= '0;
				z_s[0][l] <= Z_W'($signed(in_data.resid[l]));
			end
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		localparam z_t T = atan_step(i);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[i+1] <= 1'b0;
			else if (en)
				vld_s[i+1] <= vld_s[i];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[i+1] <= side_s[i];
				for (int l = 0; l < 3; l++) begin
					if (!z_s[i][l][Z_W-1]) begin
						x_s[i+1][l] <= x_s[i][l] - (y_s[i][l] >>> i);
						y_s[i+1][l] <= y_s[i][l] + (x_s[i][l] >>> i);
						z_s[i+1][l] <= z_s[i][l] - T;
					end else begin
						x_s[i+1][l] <= x_s[i][l] + (y_s[i][l] >>> i);
						y_s[i+1][l] <= y_s[i][l] - (x_s[i][l] >>> i);
						z_s[i+1][l] <= z_s[i][l] + T;
					end
				end
			end
		end
	end

	assign out_vld  = vld_s[CORDIC_STEPS];
	assign out_side = side_s[CORDIC_STEPS];
	for (genvar l = 0; l < 3; l++) begin : g_out
		assign out_x[l] = x_s[CORDIC_STEPS][l];
		assign out_y[l] = y_s[CORDIC_STEPS][l];
	end
endmodule

@@ hw/rtl/eyv_matrix.sv @@
// Basis vectors and translation terms from sine/cosine, last stage is the output register
module eyv_matrix import eyv_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      in_vld,
	input  xy_t [2:0] in_x,
	input  xy_t [2:0] in_y,
	input  side_t     in_side,
	output logic      out_vld,
	output res_t      out_res
);
	logic  vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	trig_t c_s1 [3];
	trig_t s_s1 [3];
	side_t side_s1, side_s2, side_s3, side_s4;
	trig_t p_s2, k_s2, c1c3_s2, c2s3_s2, c3s1_s2, c1s3_s2, c2c3_s2, s1s3_s2;
	trig_t c2s1_s2, c1c2_s2, s2_s2, c3_s2, s3_s2;
	trig_t ps3_s3, ks3_s3, pc3_s3, kc3_s3;
	trig_t c1c3_s3, c2s3_s3, c3s1_s3, c1s3_s3, c2c3_s3, s1s3_s3, c2s1_s3, c1c2_s3, s2_s3;
	trig_t e_s4 [9];
	trig_t e_s5 [9];
	trig_t e_s6 [9];
	logic signed [PROD_W-1:0] pr_s5 [9];
	logic signed [ACC_W-1:0]  acc_s6 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7} <= '0;
		end else if (en) begin
			{vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7} <=
				{in_vld, vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// round to QF, then fold the quadrant back in
			side_s1 <= in_side;
			for (int l = 0; l < 3; l++) begin
				trig_t c;
				trig_t s;
				c = rnd_q30(in_x[l]);
				s = rnd_q30(in_y[l]);
				case (in_side.quad[l])
					2'd0: begin c_s1[l] <= c;  s_s1[l] <= s;  end
					2'd1: begin c_s1[l] <= -s; s_s1[l] <= c;  end
					2'd2: begin c_s1[l] <= -c; s_s1[l] <= -s; end
					default: begin c_s1[l] <= s; s_s1[l] <= -c; end
				endcase
			end

			side_s2 <= side_s1;
			p_s2    <= fmul(s_s1[0], s_s1[1]);
			k_s2    <= fmul(c_s1[0], s_s1[1]);
			c1c3_s2 <= fmul(c_s1[0], c_s1[2]);
			c2s3_s2 <= fmul(c_s1[1], s_s1[2]);
			c3s1_s2 <= fmul(c_s1[2], s_s1[0]);
			c1s3_s2 <= fmul(c_s1[0], s_s1[2]);
			c2c3_s2 <= fmul(c_s1[1], c_s1[2]);
			s1s3_s2 <= fmul(s_s1[0], s_s1[2]);
			c2s1_s2 <= fmul(c_s1[1], s_s1[0]);
			c1c2_s2 <= fmul(c_s1[0], c_s1[1]);
			s2_s2   <= s_s1[1];
			c3_s2   <= c_s1[2];
			s3_s2   <= s_s1[2];

			side_s3 <= side_s2;
			ps3_s3  <= fmul(p_s2, s3_s2);
			ks3_s3  <= fmul(k_s2, s3_s2);
			pc3_s3  <= fmul(p_s2, c3_s2);
			kc3_s3  <= fmul(k_s2, c3_s2);
			c1c3_s3 <= c1c3_s2;
			c2s3_s3 <= c2s3_s2;
			c3s1_s3 <= c3s1_s2;
			c1s3_s3 <= c1s3_s2;
			c2c3_s3 <= c2c3_s2;
			s1s3_s3 <= s1s3_s2;
			c2s1_s3 <= c2s1_s2;
			c1c2_s3 <= c1c2_s2;
			s2_s3   <= s2_s2;

			side_s4 <= side_s3;
			e_s4[0] <= uclamp(SUM_W'(c1c3_s3) + SUM_W'(ps3_s3));
			e_s4[1] <= uclamp(SUM_W'(c2s3_s3));
			e_s4[2] <= uclamp(SUM_W'(ks3_s3) - SUM_W'(c3s1_s3));
			e_s4[3] <= uclamp(SUM_W'(pc3_s3) - SUM_W'(c1s3_s3));
			e_s4[4] <= uclamp(SUM_W'(c2c3_s3));
			e_s4[5] <= uclamp(SUM_W'(kc3_s3) + SUM_W'(s1s3_s3));
			e_s4[6] <= uclamp(SUM_W'(c2s1_s3));
			e_s4[7] <= uclamp(-SUM_W'(s2_s3));
			e_s4[8] <= uclamp(SUM_W'(c1c2_s3));

			for (int r = 0; r < 3; r++) begin
				pr_s5[3*r]   <= e_s4[3*r]   * side_s4.pos_x;
				pr_s5[3*r+1] <= e_s4[3*r+1] * side_s4.pos_y;
				pr_s5[3*r+2] <= e_s4[3*r+2] * side_s4.pos_z;
			end
			e_s5 <= e_s4;

			for (int r = 0; r < 3; r++) begin
				acc_s6[r] <= ACC_W'(pr_s5[3*r]) + ACC_W'(pr_s5[3*r+1]) +
					ACC_W'(pr_s5[3*r+2]);
			end
			e_s6 <= e_s5;

			out_res.right_x <= 16'(e_s6[0]);
			out_res.right_y <= 16'(e_s6[1]);
			out_res.right_z <= 16'(e_s6[2]);
			out_res.up_x    <= 16'(e_s6[3]);
			out_res.up_y    <= 16'(e_s6[4]);
			out_res.up_z    <= 16'(e_s6[5]);
			out_res.fwd_x   <= 16'(e_s6[6]);
			out_res.fwd_y   <= 16'(e_s6[7]);
			out_res.fwd_z   <= 16'(e_s6[8]);
			out_res.shift_u <= sat32(acc_s6[0]);
			out_res.shift_v <= sat32(acc_s6[1]);
			out_res.shift_w <= sat32(acc_s6[2]);
		end
	end

	assign out_vld = vld_s7;
endmodule

@@ hw/rtl/euler_yxz_view_matrix_unit.sv @@
// Top level of the camera pose to view matrix unit
//
// Input channel: push/full. A pose item (three 16-bit binary angles, three
// Q16.16 position words) is taken at a clock edge with push high, full low.
// It lands in a four-entry queue that also splits each angle into quadrant
// and residual. Result channel: empty/pop. While empty is low the oldest
// result (nine Q1.14 basis entries, three saturated Q16.16 translations)
// sits on the result ports; pop at an edge with empty low takes it.
// Throughput: one item per cycle while the result slot is free or popped,
// limited by the single queue read port and the fully pipelined back end
// (one CORDIC step per stage). An item passes the CORDIC pipe (load from
// the queue plus 16 steps), then the matrix pipe.
// When the receiver does not pop, the back end freezes behind the held
// result; the queue keeps taking items until it holds four, then raises
// full. Reset clears queue pointers and pipeline valid bits: the block
// comes out empty and ready, with no clearing pass.
`include "euler_yxz_view_matrix_unit_macros.svh"
module euler_yxz_view_matrix_unit import eyv_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [15:0] pitch_angle,
	input  logic signed [15:0] yaw_angle,
	input  logic signed [15:0] roll_angle,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	output logic               empty,
	input  logic               pop,
	output logic signed [15:0] right_x,
	output logic signed [15:0] right_y,
	output logic signed [15:0] right_z,
	output logic signed [15:0] up_x,
	output logic signed [15:0] up_y,
	output logic signed [15:0] up_z,
	output logic signed [15:0] fwd_x,
	output logic signed [15:0] fwd_y,
	output logic signed [15:0] fwd_z,
	output logic signed [31:0] shift_u,
	output logic signed [31:0] shift_v,
	output logic signed [31:0] shift_w
);
	fe_t       fq_data;
	fq_stat_t  fst;
	logic      adv;
	logic      fq_pop;
	logic      cor_vld;
	xy_t [2:0] cor_x;
	xy_t [2:0] cor_y;
	side_t     cor_side;
	logic      res_vld;
	res_t      res;

	// back end moves whenever the output slot is free or being drained
	assign adv    = !res_vld || pop;
	assign fq_pop = adv && !fst.empty;

	eyv_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.pitch_angle (pitch_angle),
		.yaw_angle   (yaw_angle),
		.roll_angle  (roll_angle),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pos_z       (pos_z),
		.rd_en       (fq_pop),
		.rd_data     (fq_data),
		.stat        (fst)
	);

	eyv_cordic u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (!fst.empty),
		.in_data  (fq_data),
		.out_vld  (cor_vld),
		.out_x    (cor_x),
		.out_y    (cor_y),
		.out_side (cor_side)
	);

	eyv_matrix u_matrix (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.in_vld  (cor_vld),
		.in_x    (cor_x),
		.in_y    (cor_y),
		.in_side (cor_side),
		.out_vld (res_vld),
		.out_res (res)
	);

	assign empty   = !res_vld;
	assign right_x = res.right_x;
	assign right_y = res.right_y;
	assign right_z = res.right_z;
	assign up_x    = res.up_x;
	assign up_y    = res.up_y;
	assign up_z    = res.up_z;
	assign fwd_x   = res.fwd_x;
	assign fwd_y   = res.fwd_y;
	assign fwd_z   = res.fwd_z;
	assign shift_u = res.shift_u;
	assign shift_v = res.shift_v;
	assign shift_w = res.shift_w;

	`EYV_ASSERT_NEVER(a_queue_over, fst.count > (FIFO_PTR_W+1)'(FIFO_DEPTH), "queue overfilled")
	`EYV_ASSERT_NEXT(a_stall_holds, !empty && !pop, !empty && $stable(res), "held result moved")
	`EYV_ASSERT_NEXT(a_full_holds, full && !fq_pop, full, "full queue lost an item")
endmodule
